[rtl/core/ilid_pkg.sv]
package ilid_pkg;

    // word and index widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 11;

    // operation codes
    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_INSERT     = 3'd1;
    localparam logic [2:0] OP_REMOVE_END = 3'd2;
    localparam logic [2:0] OP_REMOVE_AT  = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // command word
    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
        logic [7:0]               position;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [7:0]               entry_count;
        logic [1:0]               status;
    } t_out_word;

    // control broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     rd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

[rtl/core/ilid_cell.sv]
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_data,
    output logic signed [DATA_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic signed [DATA_W-1:0] r_tap;
    logic signed [DATA_W-1:0] n_tap;

    // entry update: shift up on insert, down on delete
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (MY_IDX > i_ctrl.idx) begin
                n_data = i_left;
            end else if (MY_IDX == i_ctrl.idx) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (MY_IDX >= i_ctrl.idx) begin
                n_data = i_right;
            end
        end
    end

    // read tap, zero unless this cell is addressed
    always_comb begin
        n_tap = '0;
        if (i_ctrl.rd && (MY_IDX == i_ctrl.idx)) begin
            n_tap = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

[rtl/core/ilid_or_tree.sv]
module ilid_or_tree
    import ilid_pkg::*;
#(
    parameter int N = 128
) (
    input  logic                          i_clk,
    input  logic [N-1:0][DATA_W-1:0]      i_taps,
    output logic [DATA_W-1:0]             o_result
);

    localparam int GROUP = 16;
    localparam int NG    = (N + GROUP - 1) / GROUP;

    logic [NG-1:0][DATA_W-1:0] r_group;
    wire  [NG-1:0][DATA_W-1:0] n_group;

    // first level: or over groups of taps
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GROUP;
        localparam int HI = ((g + 1) * GROUP < N) ? (g + 1) * GROUP : N;
        logic [DATA_W-1:0] w_or;
        always_comb begin
            w_or = '0;
            for (int k = LO; k < HI; k++) begin
                w_or = w_or | i_taps[k];
            end
        end
        assign n_group[g] = w_or;
    end

    always_ff @(posedge i_clk) begin
        r_group <= n_group;
    end

    // second level: or over group results
    always_comb begin
        o_result = '0;
        for (int g = 0; g < NG; g++) begin
            o_result = o_result | r_group[g];
        end
    end

endmodule

[rtl/core/indexed_list_insert_delete_top.sv]
// channel  | ports                    | handshake
// ---------+--------------------------+----------------------------------
// command  | i_cmd (t_in_word)        | taken when start high, busy low
// result   | o_result (t_out_word)    | o_done high for one cycle
//
// one word is taken every cycle; busy stays low. an insert or remove
// shifts the entries from its position on in the cycle it is taken.
// the result word passes through the stages of the cell read taps,
// the registered first level of the or tree and the result register.
// reset (synchronous, active low) empties the list; entry contents are
// not cleared, only entries below the count are ever read.
// results cannot be held off, so nothing inside ever stalls.
module indexed_list_insert_delete_top
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           w_accept;
    logic [IDX_W-1:0] w_cnt_x;
    logic [IDX_W-1:0] w_pos_x;
    logic           w_full;
    logic           w_empty;
    logic [1:0]     w_status;
    t_cell_ctrl     w_ctrl;

    logic           r_p1_valid;
    logic [CW-1:0]  r_p1_count;
    logic [1:0]     r_p1_status;
    logic           r_p2_valid;
    logic [CW-1:0]  r_p2_count;
    logic [1:0]     r_p2_status;
    logic           r_done;
    t_out_word      r_result;

    logic [CAPACITY-1:0][DATA_W-1:0] w_data;
    logic [CAPACITY-1:0][DATA_W-1:0] w_tap;
    logic [DATA_W-1:0]               w_read;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_cnt_x  = IDX_W'(r_count);
    assign w_pos_x  = IDX_W'(i_cmd.position);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // decode command, check limits, build cell control
    always_comb begin
        w_status     = ST_OK;
        n_count      = r_count;
        w_ctrl       = '0;
        w_ctrl.value = i_cmd.value;
        w_ctrl.idx   = w_pos_x;
        case (i_cmd.operation)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                    w_ctrl.idx = w_cnt_x;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.ins = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_REMOVE_END: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.del = 1'b1;
                    w_ctrl.idx = w_cnt_x - 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.del = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctrl.ins = 1'b0;
            w_ctrl.del = 1'b0;
            w_ctrl.rd  = 1'b0;
            n_count    = r_count;
        end
    end

    // row of cells, one entry each
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_data[i];
        end else begin : g_inner
            assign w_right = w_data[i+1];
        end
        ilid_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[i]),
            .o_tap   (w_tap[i])
        );
    end

    // gather read taps
    ilid_or_tree #(
        .N (CAPACITY)
    ) u_or_tree (
        .i_clk    (i_clk),
        .i_taps   (w_tap),
        .o_result (w_read)
    );

    // count, status pipeline and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_p1_valid <= w_accept;
            r_p2_valid <= r_p1_valid;
            r_done     <= r_p2_valid;
        end
        r_p1_count           <= n_count;
        r_p1_status          <= w_status;
        r_p2_count           <= r_p1_count;
        r_p2_status          <= r_p1_status;
        r_result.read_value  <= w_read;
        r_result.entry_count <= 8'(r_p2_count);
        r_result.status      <= r_p2_status;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
